>>> rtl/servo_bus_write_packet_framer_unit_assert.svh
// Assertion macros for the servo bus write packet framer.
// Included by the modules that check their own logic; needs a clk and rst in scope.
`ifndef SERVO_BUS_WRITE_PACKET_FRAMER_UNIT_ASSERT_SVH
`define SERVO_BUS_WRITE_PACKET_FRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property outside of reset
`define SBWPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every edge, reset included
`define SBWPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBWPF_ASSERT(lbl, prop, msg)
`define SBWPF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/sbwpf_pkg.sv
// Shared types, constants and functions of the servo bus write packet framer.
// No dependencies; imported by every module of the block.
package sbwpf_pkg;

  // Data byte limits
  localparam int MAX_DATA_BYTES = 4;
  localparam int WORD_BYTES     = 4;
  localparam int LIM_BYTES      = (MAX_DATA_BYTES < WORD_BYTES) ? MAX_DATA_BYTES : WORD_BYTES;

  localparam int CNT_W  = 3;
  localparam int IDX_W  = 4;
  localparam int SEL_W  = $clog2(WORD_BYTES);

  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(LIM_BYTES);

  // Input tdata layout
  localparam int IN_TDATA_W = 56;
  localparam int ADDR_LO    = 0;
  localparam int DATA_LO    = 16;
  localparam int CNT_LO     = 48;

  // Packet constants
  localparam logic [7:0]  HDR_A        = 8'hFF;
  localparam logic [7:0]  HDR_B        = 8'hFD;
  localparam logic [7:0]  HDR_C        = 8'h00;
  localparam logic [7:0]  INSTR_WRITE  = 8'h03;
  localparam logic [7:0]  LEN_BIAS     = 8'd5;
  localparam logic [7:0]  LEN_HIGH     = 8'h00;
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [15:0] CRC_TOP      = 16'h8000;
  localparam logic [7:0]  DEV_ID_RESET = 8'd1;

  // Byte positions within a packet
  localparam logic [IDX_W-1:0] POS_HDR0   = 4'd0;
  localparam logic [IDX_W-1:0] POS_HDR1   = 4'd1;
  localparam logic [IDX_W-1:0] POS_HDR2   = 4'd2;
  localparam logic [IDX_W-1:0] POS_HDR3   = 4'd3;
  localparam logic [IDX_W-1:0] POS_ID     = 4'd4;
  localparam logic [IDX_W-1:0] POS_LEN_L  = 4'd5;
  localparam logic [IDX_W-1:0] POS_LEN_H  = 4'd6;
  localparam logic [IDX_W-1:0] POS_INSTR  = 4'd7;
  localparam logic [IDX_W-1:0] POS_ADDR_L = 4'd8;
  localparam logic [IDX_W-1:0] POS_ADDR_H = 4'd9;
  localparam logic [IDX_W-1:0] POS_DATA   = 4'd10;

  // Request queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [7:0]       dev;
    logic [15:0]      addr;
    logic [31:0]      data;
    logic [CNT_W-1:0] cnt;
  } req_t;

  // Bring the byte count into 1..LIM_BYTES
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = raw;
    if (c < CNT_MIN) c = CNT_MIN;
    if (c > CNT_LIM) c = CNT_LIM;
    return c;
  endfunction

  // Fold one byte into the CRC-16, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

>>> rtl/sbwpf_front.sv
// Front end: holds the device id register, takes requests and normalizes them.
// Depends on sbwpf_pkg.
module sbwpf_front
  import sbwpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  req_valid,
  output req_t                  req,
  input  logic                  req_ready
);

  logic [7:0] device_id;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= DEV_ID_RESET;
    end else if (cfg_we) begin
      device_id <= cfg_wdata;
    end
  end

  assign s_tready = !req_valid || req_ready;

  // Hold valid until the queue takes the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  // Capture and clamp the request on transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.dev  <= device_id;
      req.addr <= s_tdata[ADDR_LO +: 16];
      req.data <= s_tdata[DATA_LO +: 32];
      req.cnt  <= clamp_count(s_tdata[CNT_LO +: CNT_W]);
    end
  end

endmodule

>>> rtl/sbwpf_queue.sv
// Short request queue between the front end and the byte sequencer.
// Depends on sbwpf_pkg.
module sbwpf_queue
  import sbwpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_pop,
  output req_t out_req
);

  req_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_req   = entry[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_req;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sbwpf_back.sv
// Back end: walks the packet of the request at the queue head, one byte per cycle unless the
// output stalls, folds the CRC as it goes and drives the output register. Depends on sbwpf_pkg.
`include "servo_bus_write_packet_framer_unit_assert.svh"
module sbwpf_back
  import sbwpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  req_t       q_req,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [IDX_W-1:0] crc_lo_pos;
  logic [IDX_W-1:0] last_pos;
  logic [IDX_W-1:0] data_off;
  logic [7:0]       data_byte;
  logic [7:0]       pkt_byte;
  logic             is_last;
  logic             in_body;
  logic             advance;

  assign crc_lo_pos = POS_DATA + IDX_W'(q_req.cnt);
  assign last_pos   = crc_lo_pos + 1'b1;
  assign is_last    = idx == last_pos;
  assign in_body    = idx < crc_lo_pos;
  assign data_off   = idx - POS_DATA;
  assign data_byte  = 8'(q_req.data >> {data_off[SEL_W-1:0], 3'b000});
  assign advance    = q_valid && (!m_tvalid || m_tready);
  assign q_pop      = advance && is_last;

  // Select the packet byte at the current position
  always_comb begin
    unique case (idx) inside
      POS_HDR0, POS_HDR1: pkt_byte = HDR_A;
      POS_HDR2:           pkt_byte = HDR_B;
      POS_HDR3:           pkt_byte = HDR_C;
      POS_ID:             pkt_byte = q_req.dev;
      POS_LEN_L:          pkt_byte = 8'(q_req.cnt) + LEN_BIAS;
      POS_LEN_H:          pkt_byte = LEN_HIGH;
      POS_INSTR:          pkt_byte = INSTR_WRITE;
      POS_ADDR_L:         pkt_byte = q_req.addr[7:0];
      POS_ADDR_H:         pkt_byte = q_req.addr[15:8];
      default: begin
        if (in_body)          pkt_byte = data_byte;
        else if (!is_last)    pkt_byte = crc[7:0];
        else                  pkt_byte = crc[15:8];
      end
    endcase
  end

  // Step through the packet and fold the CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= '0;
    end else if (advance) begin
      if (is_last) begin
        idx <= '0;
        crc <= '0;
      end else begin
        idx <= idx + 1'b1;
        if (in_body) crc <= crc_byte(crc, pkt_byte);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= pkt_byte;
      m_tlast <= is_last;
    end
  end

  `SBWPF_ASSERT(a_pop_on_last, q_pop |-> (q_valid && is_last), "queue popped before last byte")
  `SBWPF_ASSERT(a_idx_range, q_valid |-> (idx <= last_pos), "byte position past end of packet")
  `SBWPF_ASSERT(a_restart, q_pop |=> ((idx == '0) && (crc == '0)), "sequencer not restarted")
  `SBWPF_ASSERT_ALWAYS(a_reset, rst |=> ((idx == '0) && !m_tvalid), "reset did not clear")

endmodule

>>> rtl/servo_bus_write_packet_framer_unit.sv
// Top level of the servo bus write packet framer.
// Depends on sbwpf_pkg, sbwpf_front, sbwpf_queue and sbwpf_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | s_tdata: reg_address, data_value, byte_count
//   m_*      | out       | m_tvalid/m_tready  | m_tdata: tx_byte; m_tlast: last_byte
//   cfg_*    | in        | cfg_we             | cfg_wdata: device_id
//
// A packet of N data bytes leaves as 12+N bytes (13 to 16), one per cycle unless m_tready
// stalls, set by the byte sequencer in the back end. The first byte passes the front,
// queue and output registers. Reset (rst, synchronous) empties the queue and sets device_id
// to 1. A stall on m_tready freezes the sequencer; requests still enter until the front
// register and the two-entry queue fill, so up to two requests wait behind a packet.
module servo_bus_write_packet_framer_unit
  import sbwpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // reg_address[15:0], data_value[47:16],
                                           // byte_count[50:48], zero[55:51]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // tx_byte[7:0]
  output logic                  m_tlast    // last_byte
);

  logic req_valid;
  logic req_ready;
  req_t req;
  logic q_valid;
  logic q_pop;
  req_t q_req;

  // Accept and normalize requests
  sbwpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  // Buffer requests between the two sides
  sbwpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_req    (req),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_req   (q_req)
  );

  // Emit packet bytes
  sbwpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/servo_bus_write_packet_framer_unit_checker.sv
// Scoreboard for the servo bus write packet framer: predicts every packet byte.
// Depends on sbwpf_pkg; watches the s_*, m_* and cfg_* channels of the block.
module servo_bus_write_packet_framer_unit_checker
  import sbwpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    bytes_due
);

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  wire_byte_t wire_bytes_q[$];
  logic [7:0] servo_id;

  initial begin
    fail_count = 0;
    bytes_due  = 0;
    servo_id   = DEV_ID_RESET;
  end

  // Print one line per mismatch, up to a cap, and count it
  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, what);
    fail_count++;
  endtask

  // CRC-16, polynomial 0x8005, MSB first, no reflection
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Build the whole write packet for one request and queue its bytes
  task automatic frame_write(input logic [15:0] addr, input logic [31:0] data,
                             input logic [CNT_W-1:0] raw_cnt);
    logic [7:0]  pkt[$];
    logic [15:0] pkt_len;
    logic [15:0] crc;
    wire_byte_t  wb;
    int          n_data;
    n_data = raw_cnt;
    // Saturate the count into the supported range
    if (n_data < 1) n_data = 1;
    if (n_data > LIM_BYTES) n_data = LIM_BYTES;
    pkt_len = 16'(n_data + 5);
    pkt.push_back(HDR_A);
    pkt.push_back(HDR_A);
    pkt.push_back(HDR_B);
    pkt.push_back(HDR_C);
    pkt.push_back(servo_id);
    pkt.push_back(pkt_len[7:0]);
    pkt.push_back(pkt_len[15:8]);
    pkt.push_back(INSTR_WRITE);
    pkt.push_back(addr[7:0]);
    pkt.push_back(addr[15:8]);
    for (int i = 0; i < n_data; i++) pkt.push_back(data[8*i +: 8]);
    crc = 16'h0000;
    foreach (pkt[i]) crc = crc16_fold(crc, pkt[i]);
    pkt.push_back(crc[7:0]);
    pkt.push_back(crc[15:8]);
    foreach (pkt[i]) begin
      wb.value = pkt[i];
      wb.last  = (i == pkt.size() - 1);
      wire_bytes_q.push_back(wb);
    end
  endtask

  // Compare output transfers, then predict from input transfers and register writes
  always @(posedge clk) begin
    wire_byte_t want;
    if (rst) begin
      servo_id = DEV_ID_RESET;
      wire_bytes_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (wire_bytes_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h (last %0b) with no packet pending",
                                    m_tdata, m_tlast));
        end else begin
          want = wire_bytes_q.pop_front();
          if (m_tdata !== want.value)
            report_mismatch($sformatf("tx_byte %02h, predicted %02h", m_tdata, want.value));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_byte %0b, predicted %0b on byte %02h",
                                      m_tlast, want.last, want.value));
        end
      end
      if (s_tvalid && s_tready)
        frame_write(s_tdata[ADDR_LO +: 16], s_tdata[DATA_LO +: 32], s_tdata[CNT_LO +: CNT_W]);
      if (cfg_we) servo_id = cfg_wdata;
    end
    bytes_due = wire_bytes_q.size();
  end

endmodule

>>> tb/servo_bus_write_packet_framer_unit_tb.sv
// Testbench top for the servo bus write packet framer: drives requests and register writes.
// Depends on sbwpf_pkg, the block and servo_bus_write_packet_framer_unit_checker.
module servo_bus_write_packet_framer_unit_tb;
  import sbwpf_pkg::*;

  localparam int TIMEOUT_UNITS = 1_000_000;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [7:0]            cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  int                    fail_count;
  int                    bytes_due;
  int                    src_idle_pct = 35;
  int                    snk_idle_pct = 35;

  servo_bus_write_packet_framer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  servo_bus_write_packet_framer_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .bytes_due  (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the byte stream at random
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Abort a hung run
  initial begin
    #(TIMEOUT_UNITS);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one write request, with random idle cycles ahead, and hold until transfer
  task automatic send_write(input logic [15:0] addr, input logic [31:0] data,
                            input logic [CNT_W-1:0] cnt);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[ADDR_LO +: 16]   = addr;
    word[DATA_LO +: 32]   = data;
    word[CNT_LO +: CNT_W] = cnt;
    @(negedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every predicted byte has left the block
  task automatic wait_for_packets();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the servo id once the block is idle
  task automatic set_device_id(input logic [7:0] id);
    wait_for_packets();
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly legal counts, sometimes zero or above the limit
  function automatic logic [CNT_W-1:0] pick_count();
    int v;
    if ($urandom_range(9) < 8) return CNT_W'($urandom_range(4, 1));
    v = $urandom_range(3);
    return (v == 0) ? CNT_W'(0) : CNT_W'(v + 4);
  endfunction

  // Random requests under one idle setting, pausing now and then for a full drain
  task automatic run_random(input int n_items, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(49) == 0) wait_for_packets();
      send_write(16'($urandom), $urandom, pick_count());
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset id: field extremes, alternating bits, every count including the saturating ones
    send_write(16'h0000, 32'h0000_0000, 3'd1);
    send_write(16'hFFFF, 32'hFFFF_FFFF, 3'd4);
    send_write(16'hAAAA, 32'hAAAA_AAAA, 3'd2);
    send_write(16'h5555, 32'h5555_5555, 3'd3);
    send_write(16'h1234, 32'h1234_5678, 3'd0);
    send_write(16'h00FF, 32'hDEAD_BEEF, 3'd5);
    send_write(16'hFF00, 32'hCAFE_F00D, 3'd6);
    send_write(16'h0074, 32'h8000_0001, 3'd7);

    // Lowest and highest ids
    set_device_id(8'h00);
    send_write(16'h0000, 32'hFFFF_FFFF, 3'd4);
    send_write(16'hFFFF, 32'h0000_0000, 3'd1);
    set_device_id(8'hFF);
    send_write(16'hFFFF, 32'hFFFF_FFFF, 3'd4);
    send_write(16'h0000, 32'h0000_0000, 3'd0);
    send_write(16'h0116, 32'h0000_0800, 3'd2);

    // Random traffic: idle on both sides, a stretch without idling, then idle on both sides again
    set_device_id(8'($urandom));
    run_random(95, 35, 35);
    set_device_id(8'hFE);
    run_random(95, 0, 0);
    set_device_id(8'($urandom));
    run_random(95, 35, 35);

    wait_for_packets();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sbwpf_pkg.sv
rtl/sbwpf_front.sv
rtl/sbwpf_queue.sv
rtl/sbwpf_back.sv
rtl/servo_bus_write_packet_framer_unit.sv
tb/servo_bus_write_packet_framer_unit_checker.sv
tb/servo_bus_write_packet_framer_unit_tb.sv
